FILE: rtl/core/format_decimal_printer_assert.svh
// assertion macros for the decimal printer
`ifndef FORMAT_DECIMAL_PRINTER_ASSERT_SVH
`define FORMAT_DECIMAL_PRINTER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FDP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define FDP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fdp_pkg.sv
package fdp_pkg;

    localparam int CHAR_W     = 8;
    localparam int ARG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int STEP_W     = $clog2(ARG_W);
    localparam int DIG_W      = $clog2(NUM_DIGITS);

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_LOWER_D = 8'h64;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SIGN   = 5'b00010,
        S_CONV   = 5'b00100,
        S_DIGITS = 5'b01000,
        S_HALT   = 5'b10000
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == '1) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

FILE: rtl/core/fdp_if.sv
interface fdp_in_if;
    import fdp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] fmt_char;
    logic [ARG_W-1:0]  arg_value;
    logic              last_of_format;

    modport source (output valid, fmt_char, arg_value, last_of_format, input ready);
    modport sink   (input valid, fmt_char, arg_value, last_of_format, output ready);
endinterface

interface fdp_out_if;
    import fdp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic [CNT_W-1:0]  char_count;
    logic              run_last;
    logic              call_done;
    logic              error;

    modport source (output valid, out_char, char_count, run_last, call_done, error,
                    input ready);
    modport sink   (input valid, out_char, char_count, run_last, call_done, error,
                    output ready);
endinterface

FILE: rtl/core/format_decimal_printer.sv
// ordinary character: result registered the next cycle after acceptance; such items
// stream at one per cycle while the output register drains
// '%d' item: optional sign character, bit-serial binary to bcd of the 32-bit magnitude,
// then ten digit positions (leading zeros dropped one per cycle, last digit always shown)
// reset (synchronous, active low) clears the count, the pending '%' and the halt;
// an unknown conversion halts the block until the next reset
module format_decimal_printer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fdp_in_if.sink           i_fmt,
    fdp_out_if.source        o_chr
);
    import fdp_pkg::*;

    t_state              r_state, n_state;
    logic                r_pending, n_pending;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_last, n_last;
    logic [ARG_W-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DIG_W-1:0]    r_dig, n_dig;
    logic                r_started, n_started;

    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_ochar;
    logic [CNT_W-1:0]    r_ocnt;
    logic                r_orl, r_ocd, r_oerr;

    logic                can_load, in_rdy, in_acc;
    logic                ld, ld_rl, ld_cd, ld_err;
    logic [CHAR_W-1:0]   ld_char;
    logic [CNT_W-1:0]    ld_cnt, bumped;
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          top_dig;
    logic                dig_final;
    logic [ARG_W-1:0]    raw;

    // add-3 correction on every bcd digit
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                           : r_bcd[i*4 +: 4];
        end
    end

    assign can_load  = !r_ovalid || o_chr.ready;
    assign in_rdy    = (r_state == S_IDLE) ? can_load : (r_state == S_HALT);
    assign in_acc    = i_fmt.valid && in_rdy;
    assign bumped    = sat_inc(r_count);
    assign top_dig   = r_bcd[BCD_W-1 -: 4];
    assign dig_final = (r_dig == DIG_W'(NUM_DIGITS - 1));
    assign raw       = i_fmt.arg_value;

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_count   = r_count;
        n_last    = r_last;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_step    = r_step;
        n_dig     = r_dig;
        n_started = r_started;
        ld        = 1'b0;
        ld_char   = CH_NUL;
        ld_cnt    = r_count;
        ld_rl     = 1'b0;
        ld_cd     = 1'b0;
        ld_err    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_pending && i_fmt.fmt_char == CH_LOWER_D) begin
                        n_pending = 1'b0;
                        n_last    = i_fmt.last_of_format;
                        n_bin     = raw[ARG_W-1] ? ARG_W'(0) - raw : raw;
                        n_bcd     = '0;
                        n_step    = '0;
                        n_dig     = '0;
                        n_started = 1'b0;
                        n_state   = raw[ARG_W-1] ? S_SIGN : S_CONV;
                    end else if (r_pending || (i_fmt.fmt_char == CH_PERCENT
                                               && i_fmt.last_of_format)) begin
                        ld        = 1'b1;
                        ld_err    = 1'b1;
                        ld_rl     = 1'b1;
                        n_pending = 1'b0;
                        n_state   = S_HALT;
                    end else if (i_fmt.fmt_char == CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        ld      = 1'b1;
                        ld_char = i_fmt.fmt_char;
                        ld_cnt  = bumped;
                        ld_rl   = 1'b1;
                        ld_cd   = i_fmt.last_of_format;
                        n_count = i_fmt.last_of_format ? '0 : bumped;
                    end
                end
            end
            S_SIGN: begin
                if (can_load) begin
                    ld      = 1'b1;
                    ld_char = CH_MINUS;
                    ld_cnt  = bumped;
                    n_count = bumped;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = {bcd_adj[BCD_W-2:0], r_bin[ARG_W-1]};
                n_bin  = {r_bin[ARG_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(ARG_W - 1)) begin
                    n_state = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (!r_started && top_dig == 4'd0 && !dig_final) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig = r_dig + DIG_W'(1);
                end else if (can_load) begin
                    ld        = 1'b1;
                    ld_char   = CH_ZERO + {4'd0, top_dig};
                    ld_cnt    = bumped;
                    ld_rl     = dig_final;
                    ld_cd     = dig_final && r_last;
                    n_count   = (dig_final && r_last) ? '0 : bumped;
                    n_bcd     = {r_bcd[BCD_W-5:0], 4'd0};
                    n_dig     = r_dig + DIG_W'(1);
                    n_started = 1'b1;
                    if (dig_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HALT: begin
                n_state = S_HALT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
            r_step    <= '0;
            r_dig     <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_started <= n_started;
            r_step    <= n_step;
            r_dig     <= n_dig;
            if (ld) begin
                r_ovalid <= 1'b1;
            end else if (o_chr.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        if (ld) begin
            r_ochar <= ld_char;
            r_ocnt  <= ld_cnt;
            r_orl   <= ld_rl;
            r_ocd   <= ld_cd;
            r_oerr  <= ld_err;
        end
    end

    assign i_fmt.ready      = in_rdy;
    assign o_chr.valid      = r_ovalid;
    assign o_chr.out_char   = r_ochar;
    assign o_chr.char_count = r_ocnt;
    assign o_chr.run_last   = r_orl;
    assign o_chr.call_done  = r_ocd;
    assign o_chr.error      = r_oerr;

`include "format_decimal_printer_assert.svh"

    `FDP_ASSERT_NOW(a_accept_only_idle_or_halt, i_fmt.valid && i_fmt.ready, (r_state == S_IDLE || r_state == S_HALT), "item accepted while busy")
    `FDP_ASSERT_NOW(a_error_means_halt, o_chr.valid && o_chr.error, r_state == S_HALT, "error item shown without halt")
    `FDP_ASSERT_NEXT(a_halt_stays_silent, r_state == S_HALT && !r_ovalid, !r_ovalid && r_state == S_HALT, "halted block produced an item")
    `FDP_ASSERT_NEXT(a_conv_no_output, r_state == S_CONV && can_load, !o_chr.valid, "item loaded during conversion")

endmodule
